FILE: hdl/exponential_chirp_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// exponential chirp generator assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_CHIRP_GENERATOR_UNIT_MACROS_SVH
`define EXPONENTIAL_CHIRP_GENERATOR_UNIT_MACROS_SVH

// implication checked every clock outside reset
`define ECG_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("ecg check failed");

// next-cycle implication
`define ECG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("ecg check failed");

`endif

FILE: hdl/ecg_pkg.sv
// ----------------------------------------------------------------------------
// ecg_pkg
// shared constants and types of the exponential chirp generator
// ----------------------------------------------------------------------------
package ecg_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int CORDIC_STEPS    = 16;
    localparam int CW              = 34;

    localparam logic [47:0] ONE_Q42 = 48'h040000000000;
    localparam logic [47:0] MAX48   = 48'hFFFFFFFFFFFF;
    localparam logic [CW-1:0] CORDIC_X0 = CW'(652032874);

    localparam logic [2:0] ADDR_GROWTH = 3'd0;
    localparam logic [2:0] ADDR_TURNS  = 3'd1;
    localparam logic [2:0] ADDR_AMP    = 3'd2;
    localparam logic [2:0] ADDR_COUNT  = 3'd3;

    typedef struct packed {
        logic [47:0] growth_factor;
        logic [31:0] turns_per_unit;
        logic [14:0] amplitude;
        logic [23:0] sample_count;
    } cfg_t;

    function automatic logic [CW-1:0] atan_turn(input logic [3:0] i);
        logic [CW-1:0] v;
        case (i)
            4'd0:    v = CW'(536870912);
            4'd1:    v = CW'(316933406);
            4'd2:    v = CW'(167458907);
            4'd3:    v = CW'(85004756);
            4'd4:    v = CW'(42667331);
            4'd5:    v = CW'(21354465);
            4'd6:    v = CW'(10679838);
            4'd7:    v = CW'(5340245);
            4'd8:    v = CW'(2670163);
            4'd9:    v = CW'(1335087);
            4'd10:   v = CW'(667544);
            4'd11:   v = CW'(333772);
            4'd12:   v = CW'(166886);
            4'd13:   v = CW'(83443);
            4'd14:   v = CW'(41722);
            default: v = CW'(20861);
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/ecg_serial_mul.sv
// ----------------------------------------------------------------------------
// ecg_serial_mul
// unsigned shift-add multiplier, four multiplier bits per cycle
// ----------------------------------------------------------------------------
module ecg_serial_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] a,
    input  logic [47:0] b,
    output logic        done,
    output logic [95:0] product
);
    import ecg_pkg::*;

    logic [47:0] a_reg, a_next;
    logic [47:0] b_reg, b_next;
    logic [95:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [51:0] part;

    assign part = {4'd0, a_reg} * {48'd0, b_reg[3:0]};

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add digit product at the top, then shift right one digit
            acc_next = {({1'b0, acc_reg[95:48]} + {1'b0, part[47:0]}) , acc_reg[47:4]}
                       + {part[51:48], 92'd0};
            b_next   = {4'd0, b_reg[47:4]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd11)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: hdl/ecg_cordic.sv
// ----------------------------------------------------------------------------
// ecg_cordic
// iterative rotation-mode cordic, one step per cycle, scaled by amplitude
// ----------------------------------------------------------------------------
module ecg_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ecg_pkg::SINE_TABLE_BITS-1:0] phase,
    input  logic [14:0]                       amplitude,
    output logic                              done,
    output logic signed [15:0]                sample
);
    import ecg_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ROT, S_SCALE} state_t;

    state_t             state_reg;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic [3:0]         i_reg;
    logic               done_reg;
    logic signed [15:0] sample_reg;
    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] a32;
    logic signed [CW+16:0] prod;
    logic signed [CW+16:0] scaled;
    logic signed [16:0]  amp_s;

    always_comb
    begin
        a32 = CW'({phase, {(32 - SINE_TABLE_BITS){1'b0}}});
        if (a32[31])
            a32 = a32 - (CW'(1) <<< 32);
        z0 = a32;
        if (a32 > $signed(CW'(1) <<< 30))
            z0 = $signed(CW'(1) <<< 31) - a32;
        else if (a32 < -$signed(CW'(1) <<< 30))
            z0 = -$signed(CW'(1) <<< 31) - a32;
    end

    always_comb
    begin
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - (y_reg >>> i_reg);
            y_next = y_reg + (x_reg >>> i_reg);
            z_next = z_reg - atan_turn(i_reg);
        end
        else
        begin
            x_next = x_reg + (y_reg >>> i_reg);
            y_next = y_reg - (x_reg >>> i_reg);
            z_next = z_reg + atan_turn(i_reg);
        end
    end

    assign amp_s  = {2'b00, amplitude};
    assign prod   = y_reg * amp_s;
    assign scaled = (prod + (51'sd1 <<< 29)) >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= CORDIC_X0;
                        y_reg     <= '0;
                        z_reg     <= z0;
                        i_reg     <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                    i_reg <= i_reg + 4'd1;
                    if (i_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (scaled > 51'(amp_s))
                        sample_reg <= 16'(amp_s);
                    else if (scaled < -51'(amp_s))
                        sample_reg <= -16'(amp_s);
                    else
                        sample_reg <= scaled[15:0];
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign sample = sample_reg;
endmodule

FILE: hdl/exponential_chirp_generator_unit.sv
// ----------------------------------------------------------------------------
// exponential_chirp_generator_unit
// exponential sine sweep source, one sample per input beat
// ----------------------------------------------------------------------------
// usage:
//   each input beat (s_tdata[0] = restart) asks for one output sample beat
//   (m_tdata = sample, m_tlast = last). restart sets the sweep to sample zero
//   before the sample is formed.
//   while a sweep runs, m_tvalid rises after the digit-serial phase
//   multiply, the cordic stepping one angle per cycle plus scaling and
//   the growth update multiply, in that order.
//   an ended sweep raises m_tvalid the cycle after the input beat.
//   the block takes one item at a time.
//   the output register holds the beat; s_tready rises again only once the
//   result is taken, so a stalled receiver holds the whole block.
//   reset: r = 1.0, index 0, registers to their reset values, no beat held.
//   configuration is to be written over the 64-bit apb port while idle;
//   the user is bound to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module exponential_chirp_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ecg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PHASE, S_SINE, S_GROW, S_OUT} state_t;

    state_t       state_reg;
    cfg_t         cfg_reg;
    logic [23:0]  index_reg;
    logic [47:0]  r_reg;
    logic         last_reg;
    logic [15:0]  sample_reg;
    logic         mul_start;
    logic [47:0]  mul_a, mul_b;
    logic         mul_done;
    logic [95:0]  mul_p;
    logic         cor_start;
    logic         cor_done;
    logic signed [15:0] cor_sample;
    logic         neg_phase;
    logic [13:0]  phase_top;
    logic [SINE_TABLE_BITS-1:0] phase_cur;
    logic [47:0]  r_cur;
    logic [23:0]  idx_cur;
    logic         wr_en;
    logic [2:0]   reg_sel;
    logic [49:0]  grown;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = {1'b0, paddr[4:3]};

    always_comb
    begin
        case (reg_sel)
            ADDR_GROWTH: prdata = {16'd0, cfg_reg.growth_factor};
            ADDR_TURNS:  prdata = {32'd0, cfg_reg.turns_per_unit};
            ADDR_AMP:    prdata = {49'd0, cfg_reg.amplitude};
            ADDR_COUNT:  prdata = {40'd0, cfg_reg.sample_count};
            default:     prdata = '0;
        endcase
    end

    assign r_cur   = s_tdata[0] ? ONE_Q42 : r_reg;
    assign idx_cur = s_tdata[0] ? 24'd0 : index_reg;

    ecg_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    ecg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cor_start),
        .phase     (phase_cur),
        .amplitude (cfg_reg.amplitude),
        .done      (cor_done),
        .sample    (cor_sample)
    );

    assign mul_start = (state_reg == S_IDLE && s_tvalid && idx_cur < cfg_reg.sample_count)
                       || (state_reg == S_SINE && cor_done);
    assign mul_a = (state_reg == S_IDLE) ? (r_cur - ONE_Q42) : r_reg;
    assign mul_b = (state_reg == S_IDLE) ? {16'd0, cfg_reg.turns_per_unit}
                                         : cfg_reg.growth_factor;
    assign cor_start = (state_reg == S_PHASE) && mul_done;
    assign grown = 50'(mul_p[95:46]) + 50'(mul_p[45]);

    // r below 1.0: the 48-bit difference lacks its sign extension
    assign neg_phase = (r_reg < ONE_Q42);
    assign phase_top = mul_p[61:48]
                       - (neg_phase ? cfg_reg.turns_per_unit[13:0] : 14'd0);
    assign phase_cur = phase_top[13 -: SINE_TABLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cfg_reg.growth_factor  <= 48'h400000000000;
            cfg_reg.turns_per_unit <= '0;
            cfg_reg.amplitude      <= 15'd32767;
            cfg_reg.sample_count   <= 24'd48000;
            index_reg  <= '0;
            r_reg      <= ONE_Q42;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_sel)
                    ADDR_GROWTH: cfg_reg.growth_factor <= pwdata[47:0];
                    ADDR_TURNS:  cfg_reg.turns_per_unit <= pwdata[31:0];
                    ADDR_AMP:    cfg_reg.amplitude <= pwdata[14:0];
                    ADDR_COUNT:  cfg_reg.sample_count <= pwdata[23:0];
                    default:     ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        r_reg     <= r_cur;
                        index_reg <= idx_cur;
                        if (idx_cur >= cfg_reg.sample_count)
                        begin
                            sample_reg <= '0;
                            last_reg   <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            last_reg  <= (idx_cur + 24'd1 == cfg_reg.sample_count);
                            state_reg <= S_PHASE;
                        end
                    end
                end
                S_PHASE:
                begin
                    if (mul_done)
                        state_reg <= S_SINE;
                end
                S_SINE:
                begin
                    if (cor_done)
                    begin
                        sample_reg <= cor_sample;
                        state_reg  <= S_GROW;
                    end
                end
                S_GROW:
                begin
                    if (mul_done)
                    begin
                        r_reg     <= (grown > 50'(MAX48)) ? MAX48 : grown[47:0];
                        index_reg <= index_reg + 24'd1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = sample_reg;
    assign m_tlast  = last_reg;
endmodule

FILE: hdl/ecg_port_checker.sv
// ----------------------------------------------------------------------------
// ecg_port_checker
// port-level checks of the chirp generator, bound to the top level
// ----------------------------------------------------------------------------
`include "exponential_chirp_generator_unit_macros.svh"

module ecg_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    `ECG_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, m_tvalid, !s_tready)
    `ECG_ASSERT_NEXT(a_hold_stall, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `ECG_ASSERT_NEXT(a_in_to_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ECG_ASSERT_IMPL(a_sample_range, clk, rst_n, m_tvalid, m_tdata != 16'h8000)
endmodule

bind exponential_chirp_generator_unit ecg_port_checker u_ecg_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exponential chirp generator testbench
// drives restart beats on the input stream and compares every output sample
// and last flag with a built-in sweep predictor (q46 growth update, phase
// product, cordic sine), over a directed table and random register settings
// ----------------------------------------------------------------------------
module testbench;
    import ecg_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASES         = 18;
    localparam int PHASE_BEATS    = 64;

    typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [63:0] wdata;
        logic        restart;
        logic        typed;
        logic [15:0] typed_sample;
        logic        typed_last;
    } row_t;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } sweep_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // restart
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // sample
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    exponential_chirp_generator_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    longint unsigned growth_q46;
    longint unsigned turns_q20;
    longint unsigned peak;
    longint unsigned sweep_len;
    longint unsigned sweep_pos;
    longint unsigned ratio_q42;

    sweep_out_t  pending_samples[$];
    int          sender_idle;
    int          receiver_idle;
    int          mismatches;
    int          stall_cycles;
    logic        apb_busy;
    row_t        rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint unsigned mul_ratio(longint unsigned a, longint unsigned b);
        logic [97:0] p;
        p = 98'(a) * 98'(b) + (98'(1) << 45);
        p = p >> 46;
        if (p > 98'(MAX48))
        begin
            return longint'(MAX48);
        end
        return longint'(p[63:0]);
    endfunction

    function automatic longint sine_q30(longint z_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        z = z_in;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_turn(4'(i)));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_turn(4'(i)));
            end
        end
        return y;
    endfunction

    function automatic sweep_out_t next_sample(logic restart);
        sweep_out_t      o;
        longint unsigned frac;
        longint unsigned tbl;
        longint          z;
        longint          s;
        if (restart)
        begin
            sweep_pos = 0;
            ratio_q42 = longint'(ONE_Q42);
        end
        if (sweep_pos >= sweep_len)
        begin
            o.sample = 16'd0;
            o.last   = 1'b1;
            return o;
        end
        frac = ((ratio_q42 - longint'(ONE_Q42)) * turns_q20) & ((64'd1 << 62) - 1);
        tbl  = frac >> (62 - SINE_TABLE_BITS);
        z    = longint'((tbl << (32 - SINE_TABLE_BITS)) & 64'hFFFF_FFFF);
        if (z >= (64'sd1 <<< 31))
        begin
            z = z - (64'sd1 <<< 32);
        end
        if (z > (64'sd1 <<< 30))
        begin
            z = (64'sd1 <<< 31) - z;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z = -(64'sd1 <<< 31) - z;
        end
        s = (sine_q30(z) * longint'(peak) + (64'sd1 <<< 29)) >>> 30;
        if (s > longint'(peak))
        begin
            s = longint'(peak);
        end
        if (s < -longint'(peak))
        begin
            s = -longint'(peak);
        end
        o.sample  = s[15:0];
        o.last    = (sweep_pos + 1 == sweep_len);
        sweep_pos = (sweep_pos + 1) & 64'hFF_FFFF;
        ratio_q42 = mul_ratio(ratio_q42, growth_q46);
        return o;
    endfunction

    task automatic drain_results();
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        apb_busy <= 1'b1;
        psel     <= 1'b1;
        pwrite   <= 1'b1;
        penable  <= 1'b0;
        paddr    <= {idx[1:0], 3'b000};
        pwdata   <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        apb_busy <= 1'b0;
        case (idx)
            ADDR_GROWTH: growth_q46 = value & 64'hFFFF_FFFF_FFFF;
            ADDR_TURNS:  turns_q20  = value & 64'hFFFF_FFFF;
            ADDR_AMP:    peak       = value & 64'h7FFF;
            ADDR_COUNT:  sweep_len  = value & 64'hFF_FFFF;
            default:     ;
        endcase
    endtask

    // input beat held until taken; the driver steps the predictor on acceptance
    task automatic send_beat(logic restart, logic typed, sweep_out_t typed_out);
        sweep_out_t predicted;
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = next_sample(restart);
        pending_samples.push_back(typed ? typed_out : predicted);
        @(negedge clk);
    endtask

    task automatic end_beats();
        s_tvalid <= 1'b0;
        drain_results();
    endtask

    task automatic add_row(row_kind_t kind, logic [2:0] idx, logic [63:0] value,
                           logic restart, logic typed, logic [15:0] smp, logic lst);
        row_t r;
        r.kind = kind;
        r.reg_idx = idx;
        r.wdata = value;
        r.restart = restart;
        r.typed = typed;
        r.typed_sample = smp;
        r.typed_last = lst;
        rows.push_back(r);
    endtask

    function automatic logic [63:0] pick_value(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo + 64'd1;
        case ($urandom_range(5))
            0:       return lo;
            1:       return hi;
            default: return lo + ({$urandom, $urandom} % span);
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    always @(posedge clk)
    begin
        sweep_out_t exp_out;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected beat: sample %0d last %0b",
                             $signed(m_tdata), m_tlast);
                end
            end
            else
            begin
                exp_out = pending_samples.pop_front();
                if (m_tdata !== exp_out.sample || m_tlast !== exp_out.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                                 $signed(exp_out.sample), $signed(m_tdata),
                                 exp_out.last, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || apb_busy)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        sweep_out_t none;
        sweep_out_t typed_out;
        logic [63:0] len;
        logic [63:0] gval;
        int          mode;
        none = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 5'd0;
        pwdata   = 64'd0;
        apb_busy = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        sender_idle   = 29;
        receiver_idle = 70;
        growth_q46 = 64'd1 << 46;
        turns_q20  = 0;
        peak       = 32767;
        sweep_len  = 48000;
        sweep_pos  = 0;
        ratio_q42  = longint'(ONE_Q42);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b1, 16'd0, 1'b1);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b1, 16'd0, 1'b1);
        add_row(ROW_WRITE, ADDR_COUNT,  64'd3,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_TURNS,  64'hFFFF_FFFF,      1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_GROWTH, 64'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b1, 16'd0, 1'b1);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b1, 16'd0, 1'b1);
        add_row(ROW_WRITE, ADDR_AMP,    64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_AMP,    64'hFFFF_FFFF,      1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_TURNS,  64'h0010_0000,      1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_GROWTH, 64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_WRITE, ADDR_COUNT,  64'hFFFF_FFFF,      1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b0, 1'b0, 16'd0, 1'b0);
        add_row(ROW_ITEM,  ADDR_COUNT,  64'd0,              1'b1, 1'b0, 16'd0, 1'b0);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                end_beats();
                reg_write(rows[i].reg_idx, rows[i].wdata);
            end
            else
            begin
                typed_out.sample = rows[i].typed_sample;
                typed_out.last   = rows[i].typed_last;
                send_beat(rows[i].restart, rows[i].typed, typed_out);
            end
        end
        end_beats();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = ph / 6;
            sender_idle   = (mode == 0) ? 29 : (mode == 1) ? 70 : 0;
            receiver_idle = (mode == 0) ? 70 : (mode == 1) ? 29 : 0;
            case ($urandom_range(7))
                0:       len = 64'd0;
                1:       len = 64'hFF_FFFF;
                2:       len = 64'd1;
                default: len = 64'($urandom_range(60, 2));
            endcase
            if ($urandom_range(1) == 0)
            begin
                gval = pick_value(64'd0, 64'hFFFF_FFFF_FFFF);
            end
            else
            begin
                gval = pick_value(64'h3FF0_0000_0000, 64'h4010_0000_0000);
            end
            reg_write(ADDR_GROWTH, gval);
            reg_write(ADDR_TURNS,  pick_value(64'd0, 64'hFFFF_FFFF));
            reg_write(ADDR_AMP,    pick_value(64'd0, 64'h7FFF));
            reg_write(ADDR_COUNT,  len);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (ph == 4 && n == PHASE_BEATS / 2)
                begin
                    end_beats();
                end
                send_beat(n == 0 || $urandom_range(24) == 0, 1'b0, none);
            end
            end_beats();
        end

        if (mismatches == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/ecg_pkg.sv
hdl/ecg_serial_mul.sv
hdl/ecg_cordic.sv
hdl/exponential_chirp_generator_unit.sv
hdl/ecg_port_checker.sv
verif/testbench.sv
